/* hw/rtl/cpo_pkg.sv */
`timescale 1ns / 1ps

package cpo_pkg;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_AXIS,
        S_PROJ_OWN,
        S_PROJ_OTH,
        S_DRAIN,
        S_CMP,
        S_NEXT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic load;
        logic rotate;
        logic clear;
    } chain_ctrl_t;

endpackage

/* hw/rtl/cpo_cell.sv */
`timescale 1ns / 1ps

module cpo_cell #(
    parameter int PW = 16
) (
    input  logic                 clk,
    input  cpo_pkg::cell_ctrl_t  ctrl,
    input  logic signed [PW-1:0] load_x,
    input  logic signed [PW-1:0] load_y,
    input  logic signed [PW-1:0] shift_x,
    input  logic signed [PW-1:0] shift_y,
    output logic signed [PW-1:0] x,
    output logic signed [PW-1:0] y
);

    logic signed [PW-1:0] x_reg;
    logic signed [PW-1:0] y_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= load_x;
            y_reg <= load_y;
        end
        else if (ctrl.shift)
        begin
            x_reg <= shift_x;
            y_reg <= shift_y;
        end
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

/* hw/rtl/cpo_chain.sv */
`timescale 1ns / 1ps

module cpo_chain #(
    parameter int MAX_VERTICES = 16,
    parameter int PW           = 16,
    parameter int CW           = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cpo_pkg::chain_ctrl_t ctrl,
    input  logic signed [PW-1:0] load_x,
    input  logic signed [PW-1:0] load_y,
    output logic [CW-1:0]        count,
    output logic                 full,
    output logic signed [PW-1:0] head_x,
    output logic signed [PW-1:0] head_y,
    output logic signed [PW-1:0] second_x,
    output logic signed [PW-1:0] second_y
);

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic signed [PW-1:0] xs [MAX_VERTICES];
    logic signed [PW-1:0] ys [MAX_VERTICES];

    assign full = (count_reg == CW'(MAX_VERTICES));

    // rotation wraps at the fill count, so the stored ring stays closed
    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_cell
        cpo_pkg::cell_ctrl_t  cc;
        logic signed [PW-1:0] sx;
        logic signed [PW-1:0] sy;

        assign cc.load  = ctrl.load && !full && (count_reg == CW'(i));
        assign cc.shift = ctrl.rotate;

        if (i == MAX_VERTICES - 1)
        begin : g_end
            assign sx = xs[0];
            assign sy = ys[0];
        end
        else
        begin : g_mid
            assign sx = (count_reg == CW'(i + 1)) ? xs[0] : xs[i+1];
            assign sy = (count_reg == CW'(i + 1)) ? ys[0] : ys[i+1];
        end

        cpo_cell #(
            .PW(PW)
        ) u_cell (
            .clk     (clk),
            .ctrl    (cc),
            .load_x  (load_x),
            .load_y  (load_y),
            .shift_x (sx),
            .shift_y (sy),
            .x       (xs[i]),
            .y       (ys[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
            count_next = '0;
        else if (ctrl.load && !full)
            count_next = count_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign count    = count_reg;
    assign head_x   = xs[0];
    assign head_y   = ys[0];
    assign second_x = (count_reg == CW'(1)) ? xs[0] : xs[1];
    assign second_y = (count_reg == CW'(1)) ? ys[0] : ys[1];

endmodule

/* hw/rtl/convex_polygon_overlap_test_core.sv */
`timescale 1ns / 1ps

// Convex polygon overlap test, separating axis method on integer points.
// Input words (s_*): one vertex per word; tuser picks polygon A (0) or B (1),
// tlast marks the final vertex of the pair and starts the test. Vertices past
// MAX_VERTICES for a polygon are dropped and flagged as overflow.
// Output words (m_*): one per test, collide in bit 0, overflow in bit 1.
// Each polygon sits in a ring of vertex cells; the ring rotates so one shared
// pair of multipliers projects the head vertex each cycle of a projection pass.
// Loading accepts vertex words while no test runs. For each edge of each polygon
// the test forms the axis, projects every vertex of both polygons, drains the
// projection pipeline, compares the two spans and advances to the next edge; a
// zero-length edge is skipped. It ends early on the first separating axis.
// s_tready is low while a test runs. A finished result is held in the output
// register; if the receiver stalls, vertex words for the next pair are still
// taken, and a following test waits only to hand over its own result.
// Reset clears the vertex counts, the overflow flag and the output valid.

module convex_polygon_overlap_test_core #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] vertex_x, [31:16] vertex_y
    input  logic        s_tuser,   // [0] poly_select
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] collide, [1] overflow, [7:2] zero
);

    localparam int PW = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int AW = PW + 1;
    localparam int MW = 2 * PW + 1;
    localparam int DW = 2 * PW + 2;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    cpo_pkg::state_t      state_reg, state_next;
    logic                 shape_reg, shape_next;
    logic [CW-1:0]        edge_reg, edge_next;
    logic [CW-1:0]        proj_reg, proj_next;
    logic                 col_reg, col_next;
    logic                 ovf_reg;
    logic                 res_ovf_reg;
    logic                 m_tvalid_reg;
    logic                 m_col_reg;
    logic                 m_ovf_reg;
    logic signed [AW-1:0] ax_reg, ay_reg;
    logic                 p_valid_reg, p_span_reg, p_first_reg;
    logic signed [MW-1:0] prod_x_reg, prod_y_reg;
    logic signed [DW-1:0] lo1_reg, hi1_reg, lo2_reg, hi2_reg;

    logic                 s_acc;
    logic                 issue, issue_oth, rot_own, rot_oth, clr;
    logic                 axis_load, out_load;
    logic signed [PW-1:0] in_x, in_y;
    cpo_pkg::chain_ctrl_t ctrl_a, ctrl_b;
    logic [CW-1:0]        cnt_a, cnt_b;
    logic                 full_a, full_b;
    logic signed [PW-1:0] a_hx, a_hy, a_sx, a_sy, b_hx, b_hy, b_sx, b_sy;
    logic [CW-1:0]        n_own, n_oth;
    logic signed [PW-1:0] own_hx, own_hy, own_sx, own_sy, pr_x, pr_y;
    logic signed [AW-1:0] dx, dy;
    logic signed [MW-1:0] px_ext, py_ext, ax_ext, ay_ext;
    logic signed [DW-1:0] dot;
    logic                 ovf_hit;

    assign s_tready = (state_reg == cpo_pkg::S_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign in_x     = s_tdata[PW-1:0];
    assign in_y     = s_tdata[16+PW-1:16];
    assign ovf_hit  = s_tuser ? full_b : full_a;

    assign ctrl_a.load   = s_acc && !s_tuser;
    assign ctrl_b.load   = s_acc && s_tuser;
    assign ctrl_a.rotate = shape_reg ? rot_oth : rot_own;
    assign ctrl_b.rotate = shape_reg ? rot_own : rot_oth;
    assign ctrl_a.clear  = clr;
    assign ctrl_b.clear  = clr;

    cpo_chain #(
        .MAX_VERTICES (MAX_VERTICES),
        .PW           (PW),
        .CW           (CW)
    ) u_chain_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl_a),
        .load_x   (in_x),
        .load_y   (in_y),
        .count    (cnt_a),
        .full     (full_a),
        .head_x   (a_hx),
        .head_y   (a_hy),
        .second_x (a_sx),
        .second_y (a_sy)
    );

    cpo_chain #(
        .MAX_VERTICES (MAX_VERTICES),
        .PW           (PW),
        .CW           (CW)
    ) u_chain_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl_b),
        .load_x   (in_x),
        .load_y   (in_y),
        .count    (cnt_b),
        .full     (full_b),
        .head_x   (b_hx),
        .head_y   (b_hy),
        .second_x (b_sx),
        .second_y (b_sy)
    );

    assign n_own  = shape_reg ? cnt_b : cnt_a;
    assign n_oth  = shape_reg ? cnt_a : cnt_b;
    assign own_hx = shape_reg ? b_hx : a_hx;
    assign own_hy = shape_reg ? b_hy : a_hy;
    assign own_sx = shape_reg ? b_sx : a_sx;
    assign own_sy = shape_reg ? b_sy : a_sy;
    assign dx     = AW'(own_sx) - AW'(own_hx);
    assign dy     = AW'(own_sy) - AW'(own_hy);

    // projected point: head of own ring, or of the other ring
    assign pr_x   = (issue_oth != shape_reg) ? b_hx : a_hx;
    assign pr_y   = (issue_oth != shape_reg) ? b_hy : a_hy;
    assign px_ext = MW'(pr_x);
    assign py_ext = MW'(pr_y);
    assign ax_ext = MW'(ax_reg);
    assign ay_ext = MW'(ay_reg);
    assign dot    = DW'(prod_x_reg) + DW'(prod_y_reg);

    always_comb
    begin
        state_next = state_reg;
        shape_next = shape_reg;
        edge_next  = edge_reg;
        proj_next  = proj_reg;
        col_next   = col_reg;
        issue      = 1'b0;
        issue_oth  = 1'b0;
        rot_own    = 1'b0;
        rot_oth    = 1'b0;
        clr        = 1'b0;
        axis_load  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            cpo_pkg::S_LOAD:
            begin
                if (s_acc && s_tlast)
                    state_next = cpo_pkg::S_START;
            end
            cpo_pkg::S_START:
            begin
                shape_next = 1'b0;
                edge_next  = '0;
                if (cnt_a == '0 || cnt_b == '0)
                begin
                    col_next   = 1'b0;
                    state_next = cpo_pkg::S_OUT;
                end
                else
                    state_next = cpo_pkg::S_AXIS;
            end
            cpo_pkg::S_AXIS:
            begin
                proj_next = '0;
                if (dx == '0 && dy == '0)
                    state_next = cpo_pkg::S_NEXT;
                else
                begin
                    axis_load  = 1'b1;
                    state_next = cpo_pkg::S_PROJ_OWN;
                end
            end
            cpo_pkg::S_PROJ_OWN:
            begin
                issue   = 1'b1;
                rot_own = 1'b1;
                if (proj_reg == n_own - CW'(1))
                begin
                    proj_next  = '0;
                    state_next = cpo_pkg::S_PROJ_OTH;
                end
                else
                    proj_next = proj_reg + CW'(1);
            end
            cpo_pkg::S_PROJ_OTH:
            begin
                issue     = 1'b1;
                issue_oth = 1'b1;
                rot_oth   = 1'b1;
                if (proj_reg == n_oth - CW'(1))
                    state_next = cpo_pkg::S_DRAIN;
                else
                    proj_next = proj_reg + CW'(1);
            end
            cpo_pkg::S_DRAIN:
            begin
                state_next = cpo_pkg::S_CMP;
            end
            cpo_pkg::S_CMP:
            begin
                if (!(hi2_reg >= lo1_reg && hi1_reg >= lo2_reg))
                begin
                    col_next   = 1'b0;
                    state_next = cpo_pkg::S_OUT;
                end
                else
                    state_next = cpo_pkg::S_NEXT;
            end
            cpo_pkg::S_NEXT:
            begin
                rot_own = 1'b1;
                if (edge_reg == n_own - CW'(1))
                begin
                    edge_next = '0;
                    if (shape_reg)
                    begin
                        col_next   = 1'b1;
                        state_next = cpo_pkg::S_OUT;
                    end
                    else
                    begin
                        shape_next = 1'b1;
                        state_next = cpo_pkg::S_AXIS;
                    end
                end
                else
                begin
                    edge_next  = edge_reg + CW'(1);
                    state_next = cpo_pkg::S_AXIS;
                end
            end
            cpo_pkg::S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    clr        = 1'b1;
                    state_next = cpo_pkg::S_LOAD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cpo_pkg::S_LOAD;
            shape_reg    <= 1'b0;
            edge_reg     <= '0;
            proj_reg     <= '0;
            col_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            shape_reg   <= shape_next;
            edge_reg    <= edge_next;
            proj_reg    <= proj_next;
            col_reg     <= col_next;
            p_valid_reg <= issue;
            if (s_acc)
                ovf_reg <= s_tlast ? 1'b0 : (ovf_reg || ovf_hit);
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc && s_tlast)
            res_ovf_reg <= ovf_reg || ovf_hit;
        if (axis_load)
        begin
            ax_reg <= -dy;
            ay_reg <= dx;
        end
        p_span_reg  <= issue_oth;
        p_first_reg <= (proj_reg == '0);
        prod_x_reg  <= px_ext * ax_ext;
        prod_y_reg  <= py_ext * ay_ext;
        if (p_valid_reg)
        begin
            if (!p_span_reg)
            begin
                if (p_first_reg || dot < lo1_reg)
                    lo1_reg <= dot;
                if (p_first_reg || dot > hi1_reg)
                    hi1_reg <= dot;
            end
            else
            begin
                if (p_first_reg || dot < lo2_reg)
                    lo2_reg <= dot;
                if (p_first_reg || dot > hi2_reg)
                    hi2_reg <= dot;
            end
        end
        if (out_load)
        begin
            m_col_reg <= col_reg;
            m_ovf_reg <= res_ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_ovf_reg, m_col_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_a <= CW'(MAX_VERTICES) && cnt_b <= CW'(MAX_VERTICES))
        else $error("vertex count beyond storage");

    a_test_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_tlast) |=> state_reg == cpo_pkg::S_START)
        else $error("test did not start after final vertex");

    a_pipe_state: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (state_reg == cpo_pkg::S_PROJ_OWN ||
                         state_reg == cpo_pkg::S_PROJ_OTH ||
                         state_reg == cpo_pkg::S_DRAIN))
        else $error("projection in flight outside a pass");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpo_pkg::S_AXIS) |-> (edge_reg < n_own))
        else $error("edge index past polygon size");

endmodule

/* bench/convex_polygon_overlap_test_core_tb.sv */
`timescale 1ns / 1ps

module convex_polygon_overlap_test_core_tb;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS   = 16;

    typedef struct {
        bit          poly_b;
        logic [15:0] vx;
        logic [15:0] vy;
        bit          last;
    } vertex_word_t;

    typedef struct {
        bit collide;
        bit overflow;
    } verdict_t;

    typedef struct {
        bit          poly_b;
        logic [15:0] vx;
        logic [15:0] vy;
        bit          last;
        bit          has_known;
        bit          known_collide;
        bit          known_overflow;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] vertex_x, [31:16] vertex_y
    logic        s_tuser;   // [0] poly_select
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [0] collide, [1] overflow, [7:2] zero

    convex_polygon_overlap_test_core #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // predictor state
    longint   pa_x [MAX_VERTICES];
    longint   pa_y [MAX_VERTICES];
    longint   pb_x [MAX_VERTICES];
    longint   pb_y [MAX_VERTICES];
    int       na;
    int       nb;
    bit       ovf_seen;

    verdict_t verdict_q[$];
    int       errors;
    bit       no_idle;
    bit       hold_off;
    bit       hold_used;
    bit       stim_done;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint to_coord(logic [15:0] raw);
        int bits;
        longint v;
        bits = (COORD_BITS < 16) ? COORD_BITS : 16;
        v = raw & ((64'd1 << bits) - 1);
        if (v[bits-1])
            v = v - (64'sd1 << bits);
        return v;
    endfunction

    function automatic bit axis_separates(bit own_b, longint ax, longint ay);
        longint lo1, hi1, lo2, hi2, d;
        int k;
        lo1 = 0; hi1 = 0; lo2 = 0; hi2 = 0;
        for (k = 0; k < (own_b ? nb : na); k++) begin
            d = own_b ? pb_x[k] * ax + pb_y[k] * ay : pa_x[k] * ax + pa_y[k] * ay;
            if (k == 0 || d < lo1) lo1 = (k == 0) ? d : d;
            if (k == 0) hi1 = d; else if (d > hi1) hi1 = d;
        end
        for (k = 0; k < (own_b ? na : nb); k++) begin
            d = own_b ? pa_x[k] * ax + pa_y[k] * ay : pb_x[k] * ax + pb_y[k] * ay;
            if (k == 0 || d < lo2) lo2 = d;
            if (k == 0) hi2 = d; else if (d > hi2) hi2 = d;
        end
        return !(hi2 >= lo1 && hi1 >= lo2);
    endfunction

    function automatic bit polygons_overlap();
        int s, i, j, n;
        longint dx, dy;
        if (na == 0 || nb == 0)
            return 1'b0;
        for (s = 0; s < 2; s++) begin
            n = s ? nb : na;
            for (i = 0; i < n; i++) begin
                j = (i + 1 == n) ? 0 : i + 1;
                dx = s ? pb_x[j] - pb_x[i] : pa_x[j] - pa_x[i];
                dy = s ? pb_y[j] - pb_y[i] : pa_y[j] - pa_y[i];
                if (dx == 0 && dy == 0)
                    continue;
                if (axis_separates(s[0], -dy, dx))
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // returns 1 when the word yields a verdict
    function automatic bit predict_vertex(vertex_word_t w, output verdict_t v);
        v.collide = 1'b0;
        v.overflow = 1'b0;
        if (w.poly_b) begin
            if (nb < MAX_VERTICES)
            begin
                pb_x[nb] = to_coord(w.vx);
                pb_y[nb] = to_coord(w.vy);
                nb++;
            end
            else
                ovf_seen = 1'b1;
        end
        else begin
            if (na < MAX_VERTICES)
            begin
                pa_x[na] = to_coord(w.vx);
                pa_y[na] = to_coord(w.vy);
                na++;
            end
            else
                ovf_seen = 1'b1;
        end
        if (!w.last)
            return 1'b0;
        v.collide = polygons_overlap();
        v.overflow = ovf_seen;
        na = 0;
        nb = 0;
        ovf_seen = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_vertex(vertex_word_t w, bit has_known, bit kc, bit ko);
        verdict_t v;
        if (!no_idle)
            while ($urandom_range(99) < 13)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.vy, w.vx};
        s_tuser  <= w.poly_b;
        s_tlast  <= w.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (predict_vertex(w, v)) begin
            if (has_known && (v.collide != kc || v.overflow != ko))
                report_mismatch("table entry vs predictor", {v.overflow, v.collide},
                                {ko, kc});
            verdict_q.push_back(v);
        end
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_coord(int span);
        int r;
        r = $urandom_range(2 * span) - span;
        return r[15:0];
    endfunction

    // convex polygon: regular-ish shape around a center, counterclockwise
    task automatic send_polygon(bit poly_b, int n, int cx, int cy, int rad, bit last_at_end);
        vertex_word_t w;
        int i;
        real ang;
        for (i = 0; i < n; i++) begin
            ang = 6.283185307 * i / n;
            w.poly_b = poly_b;
            w.vx = 16'(cx + $rtoi(rad * $cos(ang)));
            w.vy = 16'(cy + $rtoi(rad * $sin(ang)));
            w.last = last_at_end && (i == n - 1);
            send_vertex(w, 1'b0, 1'b0, 1'b0);
        end
    endtask

    table_row_t dir_table[] = '{
        // single point each, same spot: no usable axis
        '{1'b0, 16'sd5, 16'sd5, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 16'sd5, 16'sd5, 1'b1, 1'b1, 1'b1, 1'b0},
        // empty polygon B
        '{1'b0, 16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b0, 1'b0},
        // empty polygon A
        '{1'b1, 16'h8000, 16'h7fff, 1'b1, 1'b1, 1'b0, 1'b0},
        // extreme triangle A against a two-point B
        '{1'b0, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'h7fff, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'h7fff, 16'h7fff, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 16'hffff, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b0},
        // separated triangles
        '{1'b0, 16'sd0,  16'sd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'sd10, 16'sd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'sd10, 16'sd10, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 16'sd20, 16'sd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 16'sd30, 16'sd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 16'sd30, 16'sd10, 1'b1, 1'b1, 1'b0, 1'b0},
        // touching edges, repeated vertex (zero-length edge)
        '{1'b0, 16'sd0,  16'sd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'sd0,  16'sd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'sd10, 16'sd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 16'sd10, 16'sd10, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 16'sd10, 16'sd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 16'sd20, 16'sd0,  1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, 16'sd20, 16'sd10, 1'b1, 1'b1, 1'b1, 1'b0}
    };

    // stimulus
    initial begin
        vertex_word_t w;
        int i, k, n;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        errors   = 0;
        na = 0; nb = 0; ovf_seen = 1'b0;
        no_idle = 1'b0;
        hold_off = 1'b0;
        hold_used = 1'b0;
        stim_done = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_table[r]) begin
            w.poly_b = dir_table[r].poly_b;
            w.vx = dir_table[r].vx;
            w.vy = dir_table[r].vy;
            w.last = dir_table[r].last;
            send_vertex(w, dir_table[r].has_known, dir_table[r].known_collide,
                        dir_table[r].known_overflow);
        end

        // overflow on both polygons
        for (i = 0; i < MAX_VERTICES + 2; i++) begin
            w.poly_b = 1'b0; w.vx = rand_coord(32767); w.vy = rand_coord(32767);
            w.last = 1'b0;
            send_vertex(w, 1'b0, 1'b0, 1'b0);
        end
        send_polygon(1'b1, MAX_VERTICES, 0, 0, 30000, 1'b0);
        w.poly_b = 1'b1; w.vx = 16'sd1; w.vy = 16'sd1; w.last = 1'b1;
        send_vertex(w, 1'b0, 1'b0, 1'b0);

        for (k = 0; k < 700; k += n) begin
            n = 0;
            no_idle = (k > 200 && k < 300);
            if (k > 400 && !hold_used)
            begin
                hold_off = 1'b1;
                hold_used = 1'b1;
            end
            case ($urandom_range(9))
                0: begin
                    // noise: random points, random split
                    n = $urandom_range(1, 20);
                    for (i = 0; i < n; i++) begin
                        w.poly_b = 1'($urandom_range(1));
                        w.vx = 16'($urandom);
                        w.vy = 16'($urandom);
                        w.last = (i == n - 1);
                        send_vertex(w, 1'b0, 1'b0, 1'b0);
                    end
                end
                1: begin
                    n = MAX_VERTICES + 1;
                    send_polygon(1'($urandom_range(1)), n, 0, 0, 20000, 1'b1);
                end
                default: begin
                    int na_r, nb_r, rad_a, rad_b;
                    na_r = ($urandom_range(9) == 0) ? MAX_VERTICES : $urandom_range(3, 6);
                    nb_r = ($urandom_range(9) == 0) ? MAX_VERTICES : $urandom_range(3, 6);
                    rad_a = $urandom_range(1, 12000);
                    rad_b = $urandom_range(1, 12000);
                    n = na_r + nb_r;
                    send_polygon(1'b0, na_r, $urandom_range(20000) - 10000,
                                 $urandom_range(20000) - 10000, rad_a, 1'b0);
                    send_polygon(1'b1, nb_r, $urandom_range(20000) - 10000,
                                 $urandom_range(20000) - 10000, rad_b, 1'b1);
                end
            endcase
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // long receiver hold-off
    initial begin
        int c;
        wait (hold_off);
        for (c = 0; c < 6000; c++)
            @(negedge clk);
        hold_off = 1'b0;
    end

    // receiver
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else if (no_idle)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 13);
        end
    end

    // checker
    always @(posedge clk) begin
        verdict_t v;
        if (rst_n && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0)
                report_mismatch("unexpected word", m_tdata, 0);
            else begin
                v = verdict_q.pop_front();
                if (m_tdata[0] !== v.collide)
                    report_mismatch("collide", m_tdata[0], v.collide);
                if (m_tdata[1] !== v.overflow)
                    report_mismatch("overflow", m_tdata[1], v.overflow);
                if (m_tdata[7:2] !== 6'd0)
                    report_mismatch("pad bits", m_tdata[7:2], 0);
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        wait (verdict_q.size() == 0);
        repeat (2000) @(posedge clk);
        if (errors == 0 && verdict_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
